/* design/bwat_pkg.sv */
// ----------------------------------------------------------------------------
// bwat_pkg
// shared types and constants of the battery window alarm with tone
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bwat_pkg;

  localparam int SAMPLE_W = 12;
  localparam int HYST_W   = 11;
  localparam int STEP_W   = 16;
  localparam int AUDIO_W  = 16;
  localparam int PHASE_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register map of the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_LIMIT  = 3'd0,
    REG_HIGH_LIMIT = 3'd1,
    REG_HYSTERESIS = 3'd2,
    REG_UNDER_STEP = 3'd3,
    REG_OVER_STEP  = 3'd4
  } cfg_index_t;

  // request and result kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RESET  = 12'd0;
  localparam logic [SAMPLE_W-1:0] HIGH_LIMIT_RESET = 12'd4095;
  localparam logic [HYST_W-1:0]   HYSTERESIS_RESET = 11'd80;
  localparam logic [STEP_W-1:0]   UNDER_STEP_RESET = 16'd3;
  localparam logic [STEP_W-1:0]   OVER_STEP_RESET  = 16'd20;

  localparam logic [PHASE_W-1:0] PHASE_STEP  = 8'd16;
  localparam logic [PHASE_W-1:0] RAMP_START  = 8'h40;
  localparam int                 AUDIO_SHIFT = 9;

  typedef struct packed {
    logic [SAMPLE_W-1:0] low_limit;
    logic [SAMPLE_W-1:0] high_limit;
    logic [HYST_W-1:0]   hysteresis;
    logic [STEP_W-1:0]   under_step;
    logic [STEP_W-1:0]   over_step;
  } cfg_regs_t;

  // item between the averaging stage and the alarm stage
  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] avg;
  } avg_item_t;

  typedef struct packed {
    logic                       kind;
    logic [SAMPLE_W-1:0]        average_code;
    logic                       alarm_on;
    logic                       below_low;
    logic signed [AUDIO_W-1:0]  audio_sample;
    logic                       tone_gate;
  } out_item_t;

endpackage

/* design/bwat_ifs.sv */
// ----------------------------------------------------------------------------
// bwat interfaces
// request, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bwat_req_if
  import bwat_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output req_type, output sample, input ready);
  modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface bwat_rsp_if
  import bwat_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [SAMPLE_W-1:0]       average_code;
  logic                      alarm_on;
  logic                      below_low;
  logic signed [AUDIO_W-1:0] audio_sample;
  logic                      tone_gate;

  modport source (output valid, output kind, output average_code, output alarm_on,
                  output below_low, output audio_sample, output tone_gate,
                  input ready);
  modport sink   (input valid, input kind, input average_code, input alarm_on,
                  input below_low, input audio_sample, input tone_gate,
                  output ready);
endinterface

interface bwat_cfg_if
  import bwat_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/bwat_accum.sv */
// ----------------------------------------------------------------------------
// bwat_accum
// block accumulator: sums samples and hands on full block sums and ticks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bwat_accum
  import bwat_pkg::*;
#(
  parameter int BLOCK_LEN = 32,
  parameter int ADC_BITS  = 12
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic                                         in_req_type,
  input  logic [SAMPLE_W-1:0]                          in_sample,
  output logic                                         s1_valid,
  input  logic                                         s1_ready,
  output logic                                         s1_kind,
  output logic [SAMPLE_W+$clog2(BLOCK_LEN)-1:0]        s1_sum
);

  localparam int CNT_W = $clog2(BLOCK_LEN);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam logic [CNT_W-1:0]    LAST        = CNT_W'(BLOCK_LEN - 1);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << ADC_BITS) - 1);

  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum_next;
  logic             accept;
  logic             block_done;

  assign in_ready   = !s1_valid || s1_ready;
  assign accept     = in_valid && in_ready;
  assign sum_next   = sum + SUM_W'(in_sample & SAMPLE_MASK);
  assign block_done = (in_req_type == REQ_SAMPLE) && (count == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      count    <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (in_req_type == REQ_SAMPLE) begin
          if (block_done) begin
            sum   <= '0;
            count <= '0;
          end else begin
            sum   <= sum_next;
            count <= count + 1'b1;
          end
        end
        // a sample short of a full block moves nothing downstream
        s1_valid <= (in_req_type == REQ_TICK) || block_done;
      end else if (s1_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind <= in_req_type;
      s1_sum  <= sum_next;
    end
  end

`ifndef SYNTHESIS
  a_block_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && block_done) |=> (count == '0 && sum == '0))
    else $error("accumulator not cleared after a full block");
`endif

endmodule

/* design/bwat_avg.sv */
// ----------------------------------------------------------------------------
// bwat_avg
// block average by reciprocal multiplication of the block sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bwat_avg
  import bwat_pkg::*;
#(
  parameter int BLOCK_LEN = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s1_valid,
  output logic                                  s1_ready,
  input  logic                                  s1_kind,
  input  logic [SAMPLE_W+$clog2(BLOCK_LEN)-1:0] s1_sum,
  output logic                                  s2_valid,
  input  logic                                  s2_ready,
  output avg_item_t                             s2_item
);

  localparam int CNT_W = $clog2(BLOCK_LEN);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int SHIFT = SUM_W + CNT_W;
  // ceil(2^SHIFT / BLOCK_LEN) gives the exact floor quotient for any SUM_W-bit sum
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN);
  localparam logic [SUM_W:0] RECIP = (SUM_W+1)'(RECIP_FULL);

  logic [2*SUM_W:0] product;
  logic             move;

  assign product  = {{(SUM_W+1){1'b0}}, s1_sum} * {{SUM_W{1'b0}}, RECIP};
  assign s1_ready = !s2_valid || s2_ready;
  assign move     = s1_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      s2_item.kind <= s1_kind;
      s2_item.avg  <= (s1_kind == REQ_SAMPLE) ? product[SHIFT +: SAMPLE_W] : '0;
    end
  end

endmodule

/* design/bwat_alarm.sv */
// ----------------------------------------------------------------------------
// bwat_alarm
// window alarm with hysteresis, tone generator and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bwat_alarm
  import bwat_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg_regs,
  input  logic      s2_valid,
  output logic      s2_ready,
  input  avg_item_t s2_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic               alarm_flag;
  logic [STEP_W-1:0]  gate_acc;
  logic [PHASE_W-1:0] phase_select;
  logic [PHASE_W-1:0] phase_ramp;
  logic [STEP_W-1:0]  active_step;

  logic               alarm_flag_next;
  logic [STEP_W-1:0]  gate_acc_next;
  logic [PHASE_W-1:0] phase_select_next;
  logic [PHASE_W-1:0] phase_ramp_next;
  logic [STEP_W-1:0]  active_step_next;
  out_item_t          out_item_next;

  logic                move;
  logic                is_below;
  logic                is_above;
  logic                in_narrow;
  logic [SAMPLE_W:0]   low_plus_hyst;
  logic [SAMPLE_W:0]   high_minus_hyst;
  logic [SAMPLE_W-1:0] ramp_bits;

  assign s2_ready = !out_valid || out_ready;
  assign move     = s2_valid && s2_ready;

  // window compares; a negative narrowed upper bound never clears
  assign low_plus_hyst   = {1'b0, cfg_regs.low_limit} + (SAMPLE_W+1)'(cfg_regs.hysteresis);
  assign high_minus_hyst = {1'b0, cfg_regs.high_limit} - (SAMPLE_W+1)'(cfg_regs.hysteresis);
  assign is_below  = s2_item.avg < cfg_regs.low_limit;
  assign is_above  = s2_item.avg > cfg_regs.high_limit;
  assign in_narrow = ({1'b0, s2_item.avg} > low_plus_hyst) && !high_minus_hyst[SAMPLE_W]
                     && (s2_item.avg < high_minus_hyst[SAMPLE_W-1:0]);

  always_comb begin
    alarm_flag_next   = alarm_flag;
    gate_acc_next     = gate_acc;
    phase_select_next = phase_select;
    phase_ramp_next   = phase_ramp;
    active_step_next  = active_step;
    ramp_bits         = '0;
    out_item_next     = '0;
    out_item_next.kind = s2_item.kind;

    if (s2_item.kind == REQ_SAMPLE) begin
      if (is_below || is_above) begin
        alarm_flag_next = 1'b1;
        if (!alarm_flag) begin
          // alarm onset: latch the tone and restart the phases
          active_step_next  = is_below ? cfg_regs.under_step : cfg_regs.over_step;
          gate_acc_next     = '0;
          phase_select_next = '0;
          phase_ramp_next   = RAMP_START;
        end
      end else if (in_narrow) begin
        alarm_flag_next = 1'b0;
      end
      out_item_next.average_code = s2_item.avg;
      out_item_next.below_low    = is_below;
      out_item_next.alarm_on     = alarm_flag_next;
    end else begin
      out_item_next.alarm_on = alarm_flag;
      if (alarm_flag) begin
        gate_acc_next     = gate_acc + active_step;
        phase_select_next = phase_select + PHASE_STEP;
        phase_ramp_next   = phase_ramp + PHASE_STEP;
        ramp_bits = {SAMPLE_W{1'b0}} | SAMPLE_W'(phase_ramp_next);
        out_item_next.tone_gate = gate_acc_next[STEP_W-1];
        if (gate_acc_next[STEP_W-1]) begin
          // ramp xor mask, shifted up: only the low ramp bits survive
          out_item_next.audio_sample =
            {ramp_bits[AUDIO_W-AUDIO_SHIFT-1:0] ^ {(AUDIO_W-AUDIO_SHIFT){~phase_select_next[PHASE_W-1]}},
             {AUDIO_SHIFT{1'b0}}};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_flag   <= 1'b0;
      gate_acc     <= '0;
      phase_select <= '0;
      phase_ramp   <= RAMP_START;
      active_step  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (s2_ready) begin
        out_valid <= s2_valid;
      end
      if (move) begin
        alarm_flag   <= alarm_flag_next;
        gate_acc     <= gate_acc_next;
        phase_select <= phase_select_next;
        phase_ramp   <= phase_ramp_next;
        active_step  <= active_step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_item <= out_item_next;
    end
  end

`ifndef SYNTHESIS
  a_below_sets_alarm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.kind == REQ_SAMPLE && out_item.below_low) |-> out_item.alarm_on)
    else $error("undervoltage result without alarm");

  a_quiet_when_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.alarm_on) |-> (out_item.audio_sample == '0 && !out_item.tone_gate))
    else $error("tone output while alarm is off");

  a_onset_restart: assert property (@(posedge clk) disable iff (rst)
    $rose(alarm_flag) |-> (gate_acc == '0 && phase_select == '0 && phase_ramp == RAMP_START))
    else $error("tone phases not restarted at alarm onset");
`endif

endmodule

/* design/battery_window_alarm_tone.sv */
// ----------------------------------------------------------------------------
// battery_window_alarm_tone
// averaged battery voltage window alarm with hysteresis and alarm tone
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                   | handshake
//  --------+-----+-------------------------------------------+-------------
//  req     | in  | req_type, sample                          | valid/ready
//  rsp     | out | kind, average_code, alarm_on, below_low,  | valid/ready
//          |     | audio_sample, tone_gate                   |
//  cfg     | in  | index, data                               | valid/ready
//
//  one request per cycle unless rsp stalls; after its transfer a result passes the
//  stages accumulate, reciprocal multiply, alarm/tone + result register
//  a sample that does not finish a block gives no result
//  rst is synchronous: limits and steps go to their defaults, state clears
//  a stalled rsp fills the three stages, then req.ready drops
//  cfg.ready is always high; writes are expected only while idle
//
`timescale 1ns / 1ps

module battery_window_alarm_tone
  import bwat_pkg::*;
#(
  parameter int BLOCK_LEN = 32,
  parameter int ADC_BITS  = 12
) (
  input  logic        clk,
  input  logic        rst,
  bwat_req_if.sink    req,
  bwat_rsp_if.source  rsp,
  bwat_cfg_if.sink    cfg
);

  localparam int SUM_W = SAMPLE_W + $clog2(BLOCK_LEN);

  cfg_regs_t        cfg_regs;
  logic             s1_valid;
  logic             s1_ready;
  logic             s1_kind;
  logic [SUM_W-1:0] s1_sum;
  logic             s2_valid;
  logic             s2_ready;
  avg_item_t        s2_item;
  out_item_t        out_item;

  // configuration registers; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.low_limit  <= LOW_LIMIT_RESET;
      cfg_regs.high_limit <= HIGH_LIMIT_RESET;
      cfg_regs.hysteresis <= HYSTERESIS_RESET;
      cfg_regs.under_step <= UNDER_STEP_RESET;
      cfg_regs.over_step  <= OVER_STEP_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LOW_LIMIT:  cfg_regs.low_limit  <= cfg.data[SAMPLE_W-1:0];
        REG_HIGH_LIMIT: cfg_regs.high_limit <= cfg.data[SAMPLE_W-1:0];
        REG_HYSTERESIS: cfg_regs.hysteresis <= cfg.data[HYST_W-1:0];
        REG_UNDER_STEP: cfg_regs.under_step <= cfg.data[STEP_W-1:0];
        REG_OVER_STEP:  cfg_regs.over_step  <= cfg.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: block sums and tick pass-through
  bwat_accum #(
    .BLOCK_LEN (BLOCK_LEN),
    .ADC_BITS  (ADC_BITS)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .in_req_type (req.req_type),
    .in_sample   (req.sample),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_kind     (s1_kind),
    .s1_sum      (s1_sum)
  );

  // stage 2: average as sum times reciprocal of the block length
  bwat_avg #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_avg (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_kind  (s1_kind),
    .s1_sum   (s1_sum),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_item  (s2_item)
  );

  // stage 3: alarm window, tone state and the result register
  bwat_alarm u_alarm (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2_item   (s2_item),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_item  (out_item)
  );

  assign rsp.kind         = out_item.kind;
  assign rsp.average_code = out_item.average_code;
  assign rsp.alarm_on     = out_item.alarm_on;
  assign rsp.below_low    = out_item.below_low;
  assign rsp.audio_sample = out_item.audio_sample;
  assign rsp.tone_gate    = out_item.tone_gate;

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the battery window alarm with tone: requests go
// in over the request channel, a transaction-level predictor in the bench computes
// every voltage update and audio sample, and a monitor compares each result
// transfer field by field, in order, under random idling and backpressure
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bwat_pkg::*;

  localparam int BLOCK_LEN     = 32;
  localparam int ADC_BITS      = 12;
  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 400000;
  // three pipeline stages plus margin, for items that leave no result
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 270;
  localparam int CODE_MAX      = 4095;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd5;

  logic clk;
  logic rst;

  bwat_req_if req_ch ();
  bwat_rsp_if rsp_ch ();
  bwat_cfg_if cfg_ch ();

  battery_window_alarm_tone #(
    .BLOCK_LEN (BLOCK_LEN),
    .ADC_BITS  (ADC_BITS)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // bench state: predictor copy of the registers and of the block's state
  // ---------------------------------------------------------------------------
  cfg_regs_t               regs_m;
  logic [16:0]             block_sum;
  int                      block_count;
  logic                    alarm_m;
  logic [STEP_W-1:0]       gate_acc;
  logic [STEP_W-1:0]       latched_step;
  logic [PHASE_W-1:0]      phase_sel;
  logic [PHASE_W-1:0]      phase_ramp;
  out_item_t               expected_rsp[$];

  int errors          = 0;
  int cycle_count     = 0;
  int items_sent      = 0;
  int send_idle_pct   = 0;
  int rsp_stall_pct   = 0;
  int hold_off_cycles = 0;

  // ---------------------------------------------------------------------------
  // clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[battery_window_alarm_tone] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  task automatic reset_model();
    regs_m.low_limit  = LOW_LIMIT_RESET;
    regs_m.high_limit = HIGH_LIMIT_RESET;
    regs_m.hysteresis = HYSTERESIS_RESET;
    regs_m.under_step = UNDER_STEP_RESET;
    regs_m.over_step  = OVER_STEP_RESET;
    block_sum    = '0;
    block_count  = 0;
    alarm_m      = 1'b0;
    gate_acc     = '0;
    latched_step = '0;
    phase_sel    = '0;
    phase_ramp   = RAMP_START;
  endtask

  // computes the result of one accepted request, if it has one
  function automatic void predict_alarm_tone(logic rt, logic [SAMPLE_W-1:0] s);
    out_item_t r;
    int        avg;
    int        lo;
    int        hi;
    int        hy;
    logic      was_on;
    logic      under;
    logic [AUDIO_W-1:0] tone;
    r = '0;
    if (rt == REQ_SAMPLE) begin
      block_sum += s;
      block_count++;
      // partial block: nothing comes out
      if (block_count < BLOCK_LEN) return;
      avg = int'(block_sum) / BLOCK_LEN;
      block_sum   = '0;
      block_count = 0;
      lo = regs_m.low_limit;
      hi = regs_m.high_limit;
      hy = regs_m.hysteresis;
      was_on = alarm_m;
      under  = 1'b0;
      // set outside the window, clear only inside the narrowed window;
      // inverted or empty windows fall out of the same literal compares
      if (avg < lo || avg > hi) begin
        under   = (avg < lo);
        alarm_m = 1'b1;
      end else if (avg > lo + hy && avg < hi - hy) begin
        alarm_m = 1'b0;
      end
      // onset only: latch the step and restart the tone
      if (!was_on && alarm_m) begin
        latched_step = under ? regs_m.under_step : regs_m.over_step;
        gate_acc     = '0;
        phase_sel    = '0;
        phase_ramp   = RAMP_START;
      end
      r.kind         = REQ_SAMPLE;
      r.average_code = avg[SAMPLE_W-1:0];
      r.alarm_on     = alarm_m;
      r.below_low    = (avg < lo);
    end else begin
      r.kind     = REQ_TICK;
      r.alarm_on = alarm_m;
      // with the alarm off the tick is silent and the tone holds still
      if (alarm_m) begin
        gate_acc   = gate_acc + latched_step;
        phase_sel  = phase_sel + PHASE_STEP;
        phase_ramp = phase_ramp + PHASE_STEP;
        if (gate_acc[STEP_W-1]) begin
          tone = {8'h00, phase_ramp} ^ (phase_sel[PHASE_W-1] ? 16'h0000 : 16'hFFFF);
          r.audio_sample = tone << AUDIO_SHIFT;
        end
        r.tone_gate = gate_acc[STEP_W-1];
      end
    end
    expected_rsp.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall, long hold-off on request, in-order check
  // ---------------------------------------------------------------------------
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        rsp_ch.ready = 1'b0;
        hold_off_cycles--;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // results are registered behind their accepted request, so the
  // expectation is always queued before the result transfer is seen
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsp.size() == 0) begin
        $error("result transfer with no expectation pending (kind %0d)", rsp_ch.kind);
        errors++;
      end else begin
        want = expected_rsp.pop_front();
        check_field("kind", want.kind, rsp_ch.kind);
        check_field("average_code", want.average_code, rsp_ch.average_code);
        check_field("alarm_on", want.alarm_on, rsp_ch.alarm_on);
        check_field("below_low", want.below_low, rsp_ch.below_low);
        check_field("audio_sample", $signed(want.audio_sample),
                    $signed(rsp_ch.audio_sample));
        check_field("tone_gate", want.tone_gate, rsp_ch.tone_gate);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side and register writes (called at the falling edge)
  // ---------------------------------------------------------------------------
  task automatic send_item(logic rt, logic [SAMPLE_W-1:0] s);
    // each cycle idles with the phase's probability; valid stays high
    // between back-to-back transfers
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid    = 1'b1;
    req_ch.req_type = rt;
    req_ch.sample   = s;
    do @(posedge clk); while (!req_ch.ready);
    predict_alarm_tone(rt, s);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(REQ_TICK, SAMPLE_W'($urandom));
  endtask

  // one full averaging block around a level, ticks mixed in between samples
  task automatic send_block(int level, int spread, int tick_pct);
    int v;
    for (int i = 0; i < BLOCK_LEN; i++) begin
      while ($urandom_range(99) < tick_pct) send_ticks(1);
      v = level + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > CODE_MAX) v = CODE_MAX;
      send_item(REQ_SAMPLE, v[SAMPLE_W-1:0]);
    end
  endtask

  // nothing in flight: queue empty and the pipeline given time to flush
  task automatic wait_idle();
    req_ch.valid = 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_LOW_LIMIT:  regs_m.low_limit  = value[SAMPLE_W-1:0];
      REG_HIGH_LIMIT: regs_m.high_limit = value[SAMPLE_W-1:0];
      REG_HYSTERESIS: regs_m.hysteresis = value[HYST_W-1:0];
      REG_UNDER_STEP: regs_m.under_step = value;
      REG_OVER_STEP:  regs_m.over_step  = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic write_window(int lo, int hi, int hy);
    wait_idle();
    write_reg(REG_LOW_LIMIT, CFG_DATA_W'(lo));
    write_reg(REG_HIGH_LIMIT, CFG_DATA_W'(hi));
    write_reg(REG_HYSTERESIS, CFG_DATA_W'(hy));
  endtask

  task automatic write_steps(logic [STEP_W-1:0] under_s, logic [STEP_W-1:0] over_s);
    wait_idle();
    write_reg(REG_UNDER_STEP, under_s);
    write_reg(REG_OVER_STEP, over_s);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: full-range window never alarms, ticks stay silent
  task automatic test_reset_defaults();
    send_ticks(3);
    send_block(2048, 0, 0);
    send_block(0, 0, 0);
    send_block(CODE_MAX, 0, 0);
    send_ticks(2);
  endtask

  // onset, stay-on, hysteresis band, clear and re-arm on the other side
  task automatic test_window_alarm();
    write_window(1000, 3000, 100);
    write_steps(16'h4000, 16'h7FFF);
    send_block(0, 0, 0);           // undervoltage onset, under step latched
    send_ticks(6);
    send_block(CODE_MAX, 0, 0);    // already on: step and phases kept
    send_ticks(2);
    send_block(1100, 0, 0);        // at lo + hy: still in the band
    send_block(2900, 0, 0);        // at hi - hy: still in the band
    send_block(2000, 0, 0);        // inside the narrowed window: clears
    send_ticks(2);
    send_block(3001, 0, 0);        // overvoltage onset, over step latched
    send_ticks(8);
    send_block(1101, 0, 0);        // just inside: clears
    send_block(2047, 2047, 0);     // wide spread exercises truncation
  endtask

  // inverted and empty windows, register extremes, masked and unmapped writes
  task automatic test_config_edges();
    write_window(3000, 1000, 0);   // inverted: any average alarms
    send_block(2000, 0, 0);
    send_ticks(3);
    send_block(2000, 0, 0);
    // hi - hy below zero: alarm can never clear
    wait_idle();
    write_reg(REG_LOW_LIMIT, 16'h0000);
    write_reg(REG_HIGH_LIMIT, 16'd50);
    write_reg(REG_HYSTERESIS, 16'hFFFF);   // upper bits dropped, 2047
    send_block(20, 0, 0);
    // clear, then undervoltage onset with the largest step
    write_window(0, CODE_MAX, 0);
    send_block(2000, 0, 0);
    write_steps(16'hFFFF, 16'h0000);
    wait_idle();
    write_reg(REG_LOW_LIMIT, 16'hFFFF);    // upper bits dropped, 4095
    write_reg(REG_HIGH_LIMIT, 16'hFFFF);
    write_reg(REG_HYSTERESIS, 16'h0000);
    write_reg(REG_UNMAPPED, 16'hFFFF);     // no register behind it
    send_block(0, 0, 0);
    send_ticks(4);
    send_block(CODE_MAX, 0, 0);            // at both limits: unchanged
    // clear, then overvoltage onset with a zero step: gate stays shut
    write_window(0, CODE_MAX, 0);
    send_block(2000, 0, 0);
    write_window(0, 0, 0);
    send_block(CODE_MAX, 0, 0);
    send_ticks(3);
  endtask

  // receiver holds off long enough for the pipeline to fill and stall requests
  task automatic test_backpressure();
    write_window(1000, 3000, 50);
    write_steps(16'h2000, 16'h5555);
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_off_cycles = 200;
    send_block(500, 4, 40);
    send_ticks(40);
    send_block(2000, 0, 20);
    wait_idle();
  endtask

  function automatic int pick_level();
    int lo;
    int hi;
    int hy;
    lo = regs_m.low_limit;
    hi = regs_m.high_limit;
    hy = regs_m.hysteresis;
    // levels sit on the decision edges most of the time
    case ($urandom_range(9))
      0: return lo - 1;
      1: return lo;
      2: return lo + hy;
      3: return lo + hy + 1;
      4: return hi - hy - 1;
      5: return hi - hy;
      6: return hi;
      7: return hi + 1;
      default: return int'($urandom_range(CODE_MAX));
    endcase
  endfunction

  task automatic randomize_regs();
    int lo;
    int hi;
    int hy;
    lo = $urandom_range(2500);
    hi = lo + int'($urandom_range(CODE_MAX - lo));
    if ($urandom_range(9) == 0) hi = $urandom_range(CODE_MAX);
    hy = ($urandom_range(3) == 0) ? int'($urandom_range(2047)) : int'($urandom_range(200));
    write_window(lo, hi, hy);
    write_steps(STEP_W'($urandom), STEP_W'($urandom));
  endtask

  // random traffic over the idling phases, new register set per phase
  task automatic test_random_traffic();
    int idle_set[4]  = '{0, 74, 0, 22};
    int stall_set[4] = '{0, 0, 74, 22};
    int start;
    for (int p = 0; p < 4; p++) begin
      randomize_regs();
      send_idle_pct = idle_set[p];
      rsp_stall_pct = stall_set[p];
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        case ($urandom_range(9))
          0, 1: send_block(2048, 2048, 30);          // noise block
          2:    send_ticks($urandom_range(1, 20));   // tick burst
          default: send_block(pick_level(),
                              ($urandom_range(1) == 0) ? 0 : int'($urandom_range(1, 8)),
                              30);
        endcase
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int drain_wait;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_SAMPLE;
    req_ch.sample   = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_LOW_LIMIT;
    cfg_ch.data     = '0;
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_window_alarm();
    test_config_edges();
    test_backpressure();
    test_random_traffic();

    // drain with a bound, then let the pipeline settle
    req_ch.valid = 1'b0;
    drain_wait = 0;
    while (expected_rsp.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_rsp.size() != 0) begin
      $error("%0d expected results never arrived", expected_rsp.size());
      errors++;
    end

    if (errors == 0) begin
      $display("[battery_window_alarm_tone] OK");
    end else begin
      $display("[battery_window_alarm_tone] ERROR");
    end
    $finish;
  end

endmodule

/* battery_window_alarm_tone.f */
design/bwat_pkg.sv
design/bwat_ifs.sv
design/bwat_accum.sv
design/bwat_avg.sv
design/bwat_alarm.sv
design/battery_window_alarm_tone.sv
dv/tb_top.sv
